// File: hdl/dfa_pkg.sv
package dfa_pkg;

    localparam int IN_W    = 16;
    localparam int OUT_W   = 48;
    localparam int MUL_W   = 35;  // signed operand width of the shared multiplier
    localparam int REM_W   = 57;
    localparam int DEN_W   = 56;
    localparam int DLOW_W  = 63;
    localparam int STEP_W  = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PREFACTOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 1'b1;

    localparam logic [31:0] PREF_RESET = 32'd16777216;
    localparam logic [15:0] CUT_RESET  = 16'd4096;

    typedef struct packed {
        logic              start;
        logic [REM_W-1:0]  rem0;
        logic [DEN_W-1:0]  den;
        logic [DLOW_W-1:0] dlow;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic              sat;
        logic [DLOW_W-1:0] quot;
    } t_div_rsp;

endpackage

// File: hdl/dfa_if.sv
interface dfa_nb_if import dfa_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] disp_x;
    logic signed [IN_W-1:0] disp_y;
    logic signed [IN_W-1:0] disp_z;
    logic signed [IN_W-1:0] nb_spin_x;
    logic signed [IN_W-1:0] nb_spin_y;
    logic signed [IN_W-1:0] nb_spin_z;
    logic        [IN_W-1:0] nb_moment;
    logic        [IN_W-1:0] target_moment;
    logic signed [IN_W-1:0] target_spin_x;
    logic signed [IN_W-1:0] target_spin_y;
    logic signed [IN_W-1:0] target_spin_z;
    logic                   last_neighbour;

    modport source (
        output valid, disp_x, disp_y, disp_z, nb_spin_x, nb_spin_y, nb_spin_z,
               nb_moment, target_moment, target_spin_x, target_spin_y, target_spin_z,
               last_neighbour,
        input  ready
    );
    modport sink (
        input  valid, disp_x, disp_y, disp_z, nb_spin_x, nb_spin_y, nb_spin_z,
               nb_moment, target_moment, target_spin_x, target_spin_y, target_spin_z,
               last_neighbour,
        output ready
    );
endinterface

interface dfa_res_if import dfa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] field_x;
    logic signed [OUT_W-1:0] field_y;
    logic signed [OUT_W-1:0] field_z;
    logic signed [OUT_W-1:0] spin_energy;

    modport source (output valid, field_x, field_y, field_z, spin_energy, input ready);
    modport sink   (input  valid, field_x, field_y, field_z, spin_energy, output ready);
endinterface

// File: hdl/dfa_div.sv
module dfa_div import dfa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic              r_sat;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DLOW_W-1:0] r_dlow;
    logic [DLOW_W-1:0] r_q;
    logic [STEP_W-1:0] r_cnt;

    logic [REM_W-1:0]  w_rem2;
    logic [REM_W-1:0]  w_sub;
    logic              w_ge;
    logic              w_sat0;

    assign w_rem2 = {r_rem, r_dlow[DLOW_W-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_den};
    assign w_sub  = w_rem2 - {1'b0, r_den};
    assign w_sat0 = i_req.rem0 >= {1'b0, i_req.den};

    // Restoring divider, one quotient bit per cycle. Start flags saturation at once
    // when the first partial remainder already reaches the divisor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_rem  <= i_req.rem0[DEN_W-1:0];
                r_den  <= i_req.den;
                r_dlow <= i_req.dlow;
                r_cnt  <= i_req.steps;
                r_q    <= '0;
                r_sat  <= w_sat0;
                r_done <= w_sat0;
                r_busy <= !w_sat0;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_sub[DEN_W-1:0] : w_rem2[DEN_W-1:0];
                r_q    <= {r_q[DLOW_W-2:0], w_ge};
                r_dlow <= {r_dlow[DLOW_W-2:0], 1'b0};
                r_cnt  <= r_cnt - STEP_W'(1);
                r_done <= (r_cnt == STEP_W'(1));
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_rsp.quot = r_q;

endmodule

// File: hdl/dipole_field_accumulator_top.sv
// Dipole field accumulator. One neighbour transaction is taken at a time; the
// input is not ready until that neighbour is fully processed. A neighbour in
// range runs an integer square root of r^2, three 15-step divisions for r_hat,
// a 63-step division for the pair weight, and a few passes through the single
// 35x35 multiplier. A neighbour at zero distance or past the cutoff goes straight
// from the range check to the finish state. A neighbour marked last then computes
// the energy and loads the result register, waiting only while an earlier result
// has not been taken; the next neighbour can be accepted while that result waits
// to be taken.
module dipole_field_accumulator_top import dfa_pkg::*; #(
    parameter int ACC_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dfa_nb_if.sink                i_nb,
    dfa_res_if.source             o_res
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_CHK, S_SQRT, S_R3, S_NUM, S_DIVW, S_DIVRH,
        S_DOT, S_T, S_CONT, S_FIN, S_E, S_OUT
    } t_state;

    t_state r_state;
    logic [1:0] r_idx;
    logic       r_phase;

    logic [31:0] r_pref;
    logic [15:0] r_cut;

    logic signed [IN_W-1:0] r_d  [3];
    logic signed [IN_W-1:0] r_s  [3];
    logic signed [IN_W-1:0] r_si [3];
    logic [IN_W-1:0]        r_mi;
    logic [IN_W-1:0]        r_mj;
    logic                   r_last;

    logic [31:0]  r_r2;
    logic [47:0]  r_sq_x;
    logic [47:0]  r_sq_res;
    logic [4:0]   r_sq_k;
    logic [23:0]  r_rq;
    logic [55:0]  r_r3;
    logic [47:0]  r_num1;
    logic [47:0]  r_numlo;
    logic [63:0]  r_num;
    logic [62:0]  r_w;
    logic signed [15:0] r_rh [3];
    logic signed [32:0] r_dot;
    logic signed [35:0] r_t  [3];
    logic [65:0]  r_plo;
    logic signed [ACC_WIDTH-1:0] r_acc [3];
    logic signed [51:0] r_e;

    logic                    r_ov;
    logic signed [OUT_W-1:0] r_of [3];
    logic signed [OUT_W-1:0] r_oe;

    logic signed [MUL_W-1:0]   w_ma;
    logic signed [MUL_W-1:0]   w_mb;
    logic signed [2*MUL_W-1:0] w_mp;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic [47:0] w_sq_bit;
    logic [47:0] w_sq_trial;
    logic [47:0] w_sq_x_nxt;
    logic [47:0] w_sq_res_nxt;
    logic        w_skip;
    logic [15:0] w_mag;
    logic [14:0] w_q15;
    logic signed [15:0] w_rh;
    logic signed [17:0] w_dot15;
    logic signed [35:0] w_t;
    logic signed [35:0] w_tabs;
    logic [33:0]  w_tm;
    logic [97:0]  w_full;
    logic [26:0]  w_cm;
    logic signed [27:0] w_c;
    logic signed [ACC_WIDTH:0]   w_sum;
    logic signed [ACC_WIDTH-1:0] w_acc_nxt;
    logic signed [64:0] w_accx [3];
    logic signed [OUT_W-1:0] w_h [3];
    logic signed [64:0] w_e_full;
    logic signed [52:0] w_ne;
    logic signed [OUT_W-1:0] w_e_sat;
    logic w_out_load;

    dfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // shared multiplier, operands chosen by the sequencer
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_SQ: begin
                w_ma = MUL_W'(r_d[r_idx]);
                w_mb = MUL_W'(r_d[r_idx]);
            end
            S_CHK: begin
                w_ma = MUL_W'(r_cut);
                w_mb = MUL_W'(r_cut);
            end
            S_R3: begin
                w_ma = MUL_W'(r_r2);
                w_mb = MUL_W'(r_rq);
            end
            S_NUM: begin
                unique case (r_idx)
                    2'd0:    w_ma = MUL_W'(r_pref);
                    2'd1:    w_ma = MUL_W'(r_num1[31:0]);
                    default: w_ma = MUL_W'(r_num1[47:32]);
                endcase
                w_mb = (r_idx == 2'd0) ? MUL_W'(r_mi) : MUL_W'(r_mj);
            end
            S_DOT: begin
                w_ma = MUL_W'(r_s[r_idx]);
                w_mb = MUL_W'(r_rh[r_idx]);
            end
            S_T: begin
                w_ma = MUL_W'(r_rh[r_idx]);
                w_mb = MUL_W'(w_dot15);
            end
            S_CONT: begin
                w_ma = MUL_W'(w_tm);
                w_mb = r_phase ? MUL_W'(r_w[62:32]) : MUL_W'(r_w[31:0]);
            end
            S_E: begin
                w_ma = MUL_W'(r_si[r_idx]);
                w_mb = r_phase ? MUL_W'(signed'(w_h[r_idx][47:24]))
                               : MUL_W'(w_h[r_idx][23:0]);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mp = w_ma * w_mb;

    // square root, two bits of the radicand per step
    assign w_sq_bit     = 48'(1) << {r_sq_k, 1'b0};
    assign w_sq_trial   = r_sq_res + w_sq_bit;
    assign w_sq_x_nxt   = (r_sq_x >= w_sq_trial) ? r_sq_x - w_sq_trial : r_sq_x;
    assign w_sq_res_nxt = (r_sq_x >= w_sq_trial) ? (r_sq_res >> 1) + w_sq_bit
                                                 : (r_sq_res >> 1);

    assign w_skip = (r_r2 == 32'd0) || (r_r2 > w_mp[31:0]);

    assign w_mag = r_d[r_idx][IN_W-1] ? 16'(-r_d[r_idx]) : 16'(r_d[r_idx]);
    assign w_q15 = w_div_rsp.sat ? 15'h7FFF : w_div_rsp.quot[14:0];
    assign w_rh  = r_d[r_idx][IN_W-1] ? -signed'({1'b0, w_q15}) : signed'({1'b0, w_q15});

    assign w_dot15 = r_dot[32:15];
    assign w_t     = (36'(signed'(w_mp[33:0])) <<< 1) + 36'(signed'(w_mp[33:0]))
                   - (36'(r_s[r_idx]) <<< 15);
    assign w_tabs  = r_t[r_idx][35] ? -r_t[r_idx] : r_t[r_idx];
    assign w_tm    = w_tabs[33:0];

    // contribution: |t| * w >> 38, with the 64-bit overflow clamp
    assign w_full = {w_mp[64:0], 32'b0} + 98'(r_plo);
    assign w_cm   = (|w_full[97:64]) ? 27'h4000000 : {1'b0, w_full[63:38]};
    assign w_c    = r_t[r_idx][35] ? -28'(w_cm) : 28'(w_cm);
    assign w_sum  = (ACC_WIDTH+1)'(r_acc[r_idx]) + (ACC_WIDTH+1)'(w_c);
    assign w_acc_nxt = (w_sum[ACC_WIDTH] != w_sum[ACC_WIDTH-1])
                     ? {w_sum[ACC_WIDTH], {(ACC_WIDTH-1){~w_sum[ACC_WIDTH]}}}
                     : w_sum[ACC_WIDTH-1:0];

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            w_accx[n] = 65'(r_acc[n]);
            if ((&w_accx[n][64:47]) || !(|w_accx[n][64:47])) begin
                w_h[n] = w_accx[n][47:0];
            end else begin
                w_h[n] = {w_accx[n][64], {47{~w_accx[n][64]}}};
            end
        end
    end

    assign w_e_full = (65'(signed'(w_mp[39:0])) <<< 24) + 65'(signed'(r_plo[40:0]));
    assign w_ne     = -(53'(r_e));
    assign w_e_sat  = ((&w_ne[52:47]) || !(|w_ne[52:47])) ? w_ne[47:0]
                    : {w_ne[52], {47{~w_ne[52]}}};

    assign w_out_load = !r_ov || o_res.ready;

    always_comb begin
        w_div_req = '0;
        if (r_state == S_DIVW && !r_phase) begin
            w_div_req.start = 1'b1;
            w_div_req.rem0  = REM_W'(r_num[63:47]);
            w_div_req.den   = r_r3;
            w_div_req.dlow  = {r_num[46:0], 16'b0};
            w_div_req.steps = STEP_W'(63);
        end else if (r_state == S_DIVRH && !r_phase) begin
            w_div_req.start = 1'b1;
            w_div_req.rem0  = REM_W'({w_mag, 8'b0});
            w_div_req.den   = DEN_W'(r_rq);
            w_div_req.dlow  = '0;
            w_div_req.steps = STEP_W'(15);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_phase <= 1'b0;
            r_ov    <= 1'b0;
            r_pref  <= PREF_RESET;
            r_cut   <= CUT_RESET;
            for (int n = 0; n < 3; n++) begin
                r_acc[n] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PREFACTOR: r_pref <= i_cfg_data;
                    CFG_CUTOFF:    r_cut  <= i_cfg_data[15:0];
                endcase
            end
            // in S_OUT the valid flag is set by the result load below
            if (r_ov && o_res.ready && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_nb.valid) begin
                        r_d[0]  <= i_nb.disp_x;
                        r_d[1]  <= i_nb.disp_y;
                        r_d[2]  <= i_nb.disp_z;
                        r_s[0]  <= i_nb.nb_spin_x;
                        r_s[1]  <= i_nb.nb_spin_y;
                        r_s[2]  <= i_nb.nb_spin_z;
                        r_si[0] <= i_nb.target_spin_x;
                        r_si[1] <= i_nb.target_spin_y;
                        r_si[2] <= i_nb.target_spin_z;
                        r_mj    <= i_nb.nb_moment;
                        r_mi    <= i_nb.target_moment;
                        r_last  <= i_nb.last_neighbour;
                        r_r2    <= '0;
                        r_dot   <= '0;
                        r_e     <= '0;
                        r_idx   <= '0;
                        r_phase <= 1'b0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_r2 <= r_r2 + w_mp[31:0];
                    if (r_idx == 2'd2) begin
                        r_idx   <= '0;
                        r_state <= S_CHK;
                    end else begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                S_CHK: begin
                    if (w_skip) begin
                        r_state <= S_FIN;
                    end else begin
                        r_sq_x   <= {r_r2, 16'b0};
                        r_sq_res <= '0;
                        r_sq_k   <= 5'd23;
                        r_state  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_sq_x   <= w_sq_x_nxt;
                    r_sq_res <= w_sq_res_nxt;
                    r_sq_k   <= r_sq_k - 5'd1;
                    if (r_sq_k == 5'd0) begin
                        r_rq    <= w_sq_res_nxt[23:0];
                        r_state <= S_R3;
                    end
                end
                S_R3: begin
                    r_r3    <= w_mp[55:0];
                    r_idx   <= '0;
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    unique case (r_idx)
                        2'd0: r_num1  <= w_mp[47:0];
                        2'd1: r_numlo <= w_mp[47:0];
                        default: begin
                            r_num   <= {w_mp[31:0], 32'b0} + {16'b0, r_numlo};
                            r_phase <= 1'b0;
                            r_state <= S_DIVW;
                        end
                    endcase
                    r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                end
                S_DIVW: begin
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else if (w_div_rsp.done) begin
                        r_w     <= w_div_rsp.sat ? '1 : w_div_rsp.quot;
                        r_phase <= 1'b0;
                        r_idx   <= '0;
                        r_state <= S_DIVRH;
                    end
                end
                S_DIVRH: begin
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else if (w_div_rsp.done) begin
                        r_rh[r_idx] <= w_rh;
                        r_phase     <= 1'b0;
                        if (r_idx == 2'd2) begin
                            r_idx   <= '0;
                            r_state <= S_DOT;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                end
                S_DOT: begin
                    r_dot <= r_dot + 33'(signed'(w_mp[31:0]));
                    if (r_idx == 2'd2) begin
                        r_idx   <= '0;
                        r_state <= S_T;
                    end else begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                S_T: begin
                    r_t[r_idx] <= w_t;
                    if (r_idx == 2'd2) begin
                        r_idx   <= '0;
                        r_phase <= 1'b0;
                        r_state <= S_CONT;
                    end else begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                S_CONT: begin
                    if (!r_phase) begin
                        r_plo   <= w_mp[65:0];
                        r_phase <= 1'b1;
                    end else begin
                        r_acc[r_idx] <= w_acc_nxt;
                        r_phase      <= 1'b0;
                        if (r_idx == 2'd2) begin
                            r_idx   <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                end
                S_FIN: begin
                    r_idx   <= '0;
                    r_phase <= 1'b0;
                    r_state <= r_last ? S_E : S_IDLE;
                end
                S_E: begin
                    if (!r_phase) begin
                        r_plo   <= w_mp[65:0];
                        r_phase <= 1'b1;
                    end else begin
                        r_e     <= r_e + 52'(signed'(w_e_full[64:15]));
                        r_phase <= 1'b0;
                        if (r_idx == 2'd2) begin
                            r_idx   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_ov <= 1'b1;
                        for (int n = 0; n < 3; n++) begin
                            r_of[n]  <= w_h[n];
                            r_acc[n] <= '0;
                        end
                        r_oe    <= w_e_sat;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_nb.ready        = (r_state == S_IDLE);
    assign o_res.valid       = r_ov;
    assign o_res.field_x     = r_of[0];
    assign o_res.field_y     = r_of[1];
    assign o_res.field_z     = r_of[2];
    assign o_res.spin_energy = r_oe;

`ifndef SYNTHESIS
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_nb.valid && i_nb.ready) |=> !i_nb.ready)
        else $error("second neighbour accepted during processing");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_load) |=>
        (r_acc[0] == '0 && r_acc[1] == '0 && r_acc[2] == '0))
        else $error("accumulators not cleared after result load");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> ((r_state == S_DIVW || r_state == S_DIVRH) && r_phase))
        else $error("divider result with no consumer waiting");
`endif

endmodule

// File: tb/sv/tb.sv
module tb;
    import dfa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] dx, dy, dz, sx, sy, sz;
        logic [15:0]        m_nb, m_tg;
        logic signed [15:0] tx, ty, tz;
        logic               last;
    } nb_item_t;

    typedef struct {
        logic signed [47:0] fx, fy, fz, en;
    } field_res_t;

    typedef struct {
        nb_item_t   it;
        bit         typed;
        field_res_t res;
    } stim_row_t;

    localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam int     WDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    dfa_nb_if  nb_ch ();
    dfa_res_if res_ch ();

    dipole_field_accumulator_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_nb       (nb_ch.sink),
        .o_res      (res_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    longint unsigned pref_q = 64'd16777216;
    longint unsigned cut_q  = 64'd4096;
    longint          fsum[3];

    field_res_t expected_fields[$];
    int  fail_cnt = 0;
    int  idle_cycles = 0;
    bit  long_hold = 1'b0;

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned scaled_quot(longint unsigned num, longint unsigned den);
        longint unsigned lim, q, r;
        lim = 64'h7FFF_FFFF_FFFF_FFFF;
        q = num / den;
        r = num % den;
        if (q > lim) return lim;
        for (int i = 0; i < 16; i++) begin
            if (q > (lim >> 1)) return lim;
            r <<= 1;
            q <<= 1;
            if (r >= den) begin
                r -= den;
                q |= 1;
            end
        end
        return q;
    endfunction

    function automatic longint floor_sh(longint v, int k);
        if (v >= 0) return v >>> k;
        return -1 - ((-1 - v) >>> k);
    endfunction

    function automatic longint clampl(longint v);
        return v < ACC_MIN ? ACC_MIN : (v > ACC_MAX ? ACC_MAX : v);
    endfunction

    function automatic void add_dipole(nb_item_t it);
        longint d[3], s[3], rh[3], dot30, dot15, t, c;
        longint unsigned r2, rq, num, w, mag, q, tm, cm;
        d[0] = longint'(it.dx); d[1] = longint'(it.dy); d[2] = longint'(it.dz);
        s[0] = longint'(it.sx); s[1] = longint'(it.sy); s[2] = longint'(it.sz);
        r2 = 0;
        dot30 = 0;
        for (int n = 0; n < 3; n++) r2 += d[n] * d[n];
        if (r2 == 0 || r2 > cut_q * cut_q) return;
        rq = isqrt(r2 << 16);
        for (int n = 0; n < 3; n++) begin
            mag = d[n] < 0 ? -d[n] : d[n];
            q = (mag << 23) / rq;
            if (q > 32767) q = 32767;
            rh[n] = d[n] < 0 ? -longint'(q) : longint'(q);
            dot30 += s[n] * rh[n];
        end
        dot15 = floor_sh(dot30, 15);
        num = pref_q * longint'(it.m_tg) * longint'(it.m_nb);
        w = scaled_quot(num, r2 * rq);
        for (int n = 0; n < 3; n++) begin
            t = 3 * rh[n] * dot15 - s[n] * 32768;
            tm = t < 0 ? -t : t;
            if (w != 0 && tm > 64'hFFFF_FFFF_FFFF_FFFF / w) cm = 64'd1 << 26;
            else cm = (tm * w) >> 38;
            c = t < 0 ? -longint'(cm) : longint'(cm);
            fsum[n] = clampl(fsum[n] + c);
        end
    endfunction

    // returns 1 and fills r when the neighbour closes a target
    function automatic bit predict_field(nb_item_t it, output field_res_t r);
        longint e, tg[3];
        add_dipole(it);
        if (!it.last) return 0;
        tg[0] = longint'(it.tx); tg[1] = longint'(it.ty); tg[2] = longint'(it.tz);
        e = 0;
        for (int n = 0; n < 3; n++) e += floor_sh(tg[n] * fsum[n], 15);
        r.fx = 48'(fsum[0]); r.fy = 48'(fsum[1]); r.fz = 48'(fsum[2]);
        r.en = 48'(clampl(-e));
        fsum[0] = 0; fsum[1] = 0; fsum[2] = 0;
        return 1;
    endfunction

    function automatic nb_item_t rand_item(int mode);
        nb_item_t it;
        it.sx = 16'($urandom); it.sy = 16'($urandom); it.sz = 16'($urandom);
        it.m_nb = 16'($urandom); it.m_tg = 16'($urandom);
        it.tx = 16'($urandom); it.ty = 16'($urandom); it.tz = 16'($urandom);
        it.last = ($urandom_range(0, 5) == 0);
        if (mode == 0) begin
            // each component within -1024..1024, so the cutoff usually passes
            it.dx = 16'($signed($urandom_range(0, 2048)) - 1024);
            it.dy = 16'($signed($urandom_range(0, 2048)) - 1024);
            it.dz = 16'($signed($urandom_range(0, 2048)) - 1024);
        end else begin
            it.dx = 16'($urandom); it.dy = 16'($urandom); it.dz = 16'($urandom);
        end
        return it;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PREFACTOR) pref_q = 64'(val);
        else cut_q = 64'(val[15:0]);
    endtask

    // valid stays up after an accept so a back-to-back transaction needs one
    // assignment only; it drops when a gap is drawn or the input is drained
    task automatic send_item(nb_item_t it);
        field_res_t r;
        int gap;
        gap = $urandom_range(0, 9);
        if (gap != 0) begin
            nb_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        nb_ch.valid          <= 1'b1;
        nb_ch.disp_x         <= it.dx;
        nb_ch.disp_y         <= it.dy;
        nb_ch.disp_z         <= it.dz;
        nb_ch.nb_spin_x      <= it.sx;
        nb_ch.nb_spin_y      <= it.sy;
        nb_ch.nb_spin_z      <= it.sz;
        nb_ch.nb_moment      <= it.m_nb;
        nb_ch.target_moment  <= it.m_tg;
        nb_ch.target_spin_x  <= it.tx;
        nb_ch.target_spin_y  <= it.ty;
        nb_ch.target_spin_z  <= it.tz;
        nb_ch.last_neighbour <= it.last;
        do @(posedge i_clk); while (!nb_ch.ready);
        if (predict_field(it, r)) expected_fields.push_back(r);
    endtask

    task automatic drain;
        nb_ch.valid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // result sink: random stalls, plus one long hold-off
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                res_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                long_hold = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    always @(posedge i_clk) begin
        field_res_t e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_fields.size() == 0) begin
                $error("unexpected result transaction");
                fail_cnt++;
            end else begin
                e = expected_fields.pop_front();
                if (res_ch.field_x !== e.fx) begin
                    $error("field_x exp %0d got %0d", e.fx, res_ch.field_x); fail_cnt++;
                end
                if (res_ch.field_y !== e.fy) begin
                    $error("field_y exp %0d got %0d", e.fy, res_ch.field_y); fail_cnt++;
                end
                if (res_ch.field_z !== e.fz) begin
                    $error("field_z exp %0d got %0d", e.fz, res_ch.field_z); fail_cnt++;
                end
                if (res_ch.spin_energy !== e.en) begin
                    $error("spin_energy exp %0d got %0d", e.en, res_ch.spin_energy);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((nb_ch.valid && nb_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic stim_row_t row(logic signed [15:0] dx, dy, dz, sx, sy, sz,
                                      logic [15:0] mn, mt, logic last, bit typed,
                                      logic signed [47:0] fx, fy, fz, en);
        stim_row_t r;
        r.it = '{dx, dy, dz, sx, sy, sz, mn, mt, 16'sh7FFF, 16'sh8000, 16'sh0001, last};
        r.typed = typed;
        r.res = '{fx, fy, fz, en};
        return r;
    endfunction

    initial begin
        stim_row_t dir[$];
        field_res_t got;
        nb_item_t it;
        nb_ch.valid = 1'b0;
        nb_ch.disp_x = '0; nb_ch.disp_y = '0; nb_ch.disp_z = '0;
        nb_ch.nb_spin_x = '0; nb_ch.nb_spin_y = '0; nb_ch.nb_spin_z = '0;
        nb_ch.nb_moment = '0; nb_ch.target_moment = '0;
        nb_ch.target_spin_x = '0; nb_ch.target_spin_y = '0; nb_ch.target_spin_z = '0;
        nb_ch.last_neighbour = 1'b0;
        fsum[0] = 0; fsum[1] = 0; fsum[2] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // self neighbour and out-of-range neighbour marked last: zero field
        dir.push_back(row(0, 0, 0, 16'sh7FFF, 0, 0, 16'hFFFF, 16'hFFFF, 1, 1, 0, 0, 0, 0));
        dir.push_back(row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1, 1, 1, 16'h1000, 16'h1000,
                          1, 1, 0, 0, 0, 0));
        dir.push_back(row(16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 16'h1000, 16'h1000,
                          1, 1, 0, 0, 0, 0));
        // zero moment contributes nothing
        dir.push_back(row(256, 0, 0, 16'sh7FFF, 0, 0, 0, 16'hFFFF, 1, 1, 0, 0, 0, 0));
        dir.push_back(row(256, 0, 0, 16'sh7FFF, 0, 0, 16'h1000, 16'h1000, 1, 0, 0, 0, 0, 0));
        dir.push_back(row(0, 256, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 16'hFFFF,
                          0, 0, 0, 0, 0, 0));
        dir.push_back(row(0, 0, -256, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF,
                          1, 0, 0, 0, 0, 0));
        dir.push_back(row(1, 0, 0, 16'sh7FFF, 16'sh8000, 0, 16'hFFFF, 16'hFFFF, 0, 0,
                          0, 0, 0, 0));
        dir.push_back(row(-1, 1, -1, 16'sh7FFF, 16'sh7FFF, 0, 16'hFFFF, 16'hFFFF, 1, 0,
                          0, 0, 0, 0));
        dir.push_back(row(4096, 0, 0, 0, 16'sh7FFF, 0, 16'h1000, 16'h1000, 1, 0, 0, 0, 0, 0));
        dir.push_back(row(4096, 1, 0, 0, 16'sh7FFF, 0, 16'h1000, 16'h1000, 1, 1, 0, 0, 0, 0));

        foreach (dir[i]) begin
            if (dir[i].typed) begin
                send_item(dir[i].it);
                got = expected_fields[$];
                if (got != dir[i].res) begin
                    $error("directed row %0d: predictor disagrees with table", i);
                    fail_cnt++;
                end
            end else begin
                send_item(dir[i].it);
            end
        end
        drain();

        // config extremes
        write_reg(CFG_PREFACTOR, 32'hFFFF_FFFF);
        write_reg(CFG_CUTOFF, 32'hFFFF);
        for (int k = 0; k < 6; k++) send_item(rand_item(k & 1));
        it = rand_item(0);
        it.last = 1'b1;
        send_item(it);
        drain();
        write_reg(CFG_PREFACTOR, 32'd0);
        write_reg(CFG_CUTOFF, 32'd0);
        for (int k = 0; k < 6; k++) send_item(rand_item(0));
        it.last = 1'b1;
        send_item(it);
        drain();

        // long receiver hold-off while neighbours keep coming
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_PREFACTOR, ph == 3 ? 32'hFFFF_FFFF : $urandom);
            write_reg(CFG_CUTOFF, ph == 2 ? 32'hFFFF : 32'($urandom_range(256, 3000)));
            if (ph == 1) long_hold = 1'b1;
            for (int k = 0; k < 480; k++) send_item(rand_item($urandom_range(0, 4) == 0));
            it = rand_item(0);
            it.last = 1'b1;
            send_item(it);
            drain();
        end
        write_reg(CFG_PREFACTOR, 32'd16777216);
        write_reg(CFG_CUTOFF, 32'd4096);

        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
